FILE: hw/rtl/itns_pkg.sv
`timescale 1ns / 1ps
package itns_pkg;

	// fraction bits of the logarithm datapath
	localparam int LOG_BITS = 60;

	// configuration register indexes
	localparam logic [2:0] CFG_REF_TEMP   = 3'd0;
	localparam logic [2:0] CFG_INV_REF    = 3'd1;
	localparam logic [2:0] CFG_GAS_LAT    = 3'd2;
	localparam logic [2:0] CFG_COEF_CONST = 3'd3;
	localparam logic [2:0] CFG_COEF_SLOPE = 3'd4;
	localparam logic [2:0] CFG_TOLERANCE  = 3'd5;
	localparam logic [2:0] CFG_MAX_ITER   = 3'd6;

	// microprogram addresses
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_SEED  = 5'd0;
	localparam logic [PC_W-1:0] PC_RESID = 5'd4;
	localparam logic [PC_W-1:0] PC_CHECK = 5'd11;
	localparam logic [PC_W-1:0] PC_STEP  = 5'd12;
	localparam logic [PC_W-1:0] PC_LAST  = 5'd17;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_LN
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [3:0] {
		AR_IDLE,
		AR_MUL,
		AR_MULF,
		AR_DSET,
		AR_DIV,
		AR_DIVF,
		AR_NORM,
		AR_LOG,
		AR_LNF,
		AR_DONE
	} ar_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_ISSUE,
		SQ_WAIT,
		SQ_FIN
	} seq_state_t;

	typedef enum logic [3:0] {
		SRC_ZERO,
		SRC_ONE,
		SRC_ALPHA,
		SRC_LNA,
		SRC_TAU,
		SRC_ERR,
		SRC_T0,
		SRC_T1,
		SRC_REF,
		SRC_INV,
		SRC_GOL,
		SRC_CC,
		SRC_CS
	} src_t;

	typedef enum logic [2:0] {
		DST_LNA,
		DST_TAU,
		DST_ERR,
		DST_T0,
		DST_T1
	} dst_t;

	typedef enum logic {
		UK_ALU,
		UK_CHECK
	} uop_kind_t;

	typedef struct packed {
		uop_kind_t       kind;
		alu_op_t         op;
		src_t            a;
		src_t            b;
		dst_t            dst;
		logic [PC_W-1:0] nxt;
	} uop_t;

	typedef logic [63:0] ln_tab_t [LOG_BITS+1];

	// floor(2^j / n) by restoring long division
	function automatic logic [63:0] pow2_over(input int j, input int n);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], (b == j)};
			if (rem >= 64'(n)) begin
				rem = rem - 64'(n);
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// -ln(1 - 2^-k) with LOG_BITS fraction bits, series truncated term by term
	function automatic ln_tab_t build_ln_tab();
		ln_tab_t     tab;
		logic [63:0] s;
		tab[0] = '0;
		for (int k = 1; k <= LOG_BITS; k++) begin
			s = '0;
			for (int n = 1; n <= LOG_BITS; n++) begin
				if (n * k <= LOG_BITS)
					s = s + pow2_over(LOG_BITS - n * k, n);
			end
			tab[k] = s;
		end
		return tab;
	endfunction

	localparam ln_tab_t LN_TAB = build_ln_tab();

	function automatic uop_t mk(input uop_kind_t kind, input alu_op_t op, input src_t a,
		input src_t b, input dst_t dst, input logic [PC_W-1:0] nxt);
		uop_t u;
		u.kind = kind;
		u.op   = op;
		u.a    = a;
		u.b    = b;
		u.dst  = dst;
		u.nxt  = nxt;
		return u;
	endfunction

	// seed, residual, newton step and final division
	function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			5'd0:    u = mk(UK_ALU, ALU_LN, SRC_ALPHA, SRC_ZERO, DST_LNA, 5'd1);
			5'd1:    u = mk(UK_ALU, ALU_MUL, SRC_GOL, SRC_LNA, DST_T0, 5'd2);
			5'd2:    u = mk(UK_ALU, ALU_SUB, SRC_INV, SRC_T0, DST_T0, 5'd3);
			5'd3:    u = mk(UK_ALU, ALU_MUL, SRC_REF, SRC_T0, DST_TAU, PC_RESID);
			5'd4:    u = mk(UK_ALU, ALU_SUB, SRC_ZERO, SRC_LNA, DST_T0, 5'd5);
			5'd5:    u = mk(UK_ALU, ALU_SUB, SRC_ONE, SRC_TAU, DST_T1, 5'd6);
			5'd6:    u = mk(UK_ALU, ALU_MUL, SRC_CC, SRC_T1, DST_T1, 5'd7);
			5'd7:    u = mk(UK_ALU, ALU_ADD, SRC_T0, SRC_T1, DST_T0, 5'd8);
			5'd8:    u = mk(UK_ALU, ALU_LN, SRC_TAU, SRC_ZERO, DST_T1, 5'd9);
			5'd9:    u = mk(UK_ALU, ALU_MUL, SRC_CS, SRC_T1, DST_T1, 5'd10);
			5'd10:   u = mk(UK_ALU, ALU_SUB, SRC_T0, SRC_T1, DST_ERR, PC_CHECK);
			5'd11:   u = mk(UK_CHECK, ALU_ADD, SRC_ZERO, SRC_ZERO, DST_T0, PC_STEP);
			5'd12:   u = mk(UK_ALU, ALU_DIV, SRC_CS, SRC_TAU, DST_T0, 5'd13);
			5'd13:   u = mk(UK_ALU, ALU_SUB, SRC_ZERO, SRC_CC, DST_T1, 5'd14);
			5'd14:   u = mk(UK_ALU, ALU_SUB, SRC_T1, SRC_T0, DST_T0, 5'd15);
			5'd15:   u = mk(UK_ALU, ALU_DIV, SRC_ERR, SRC_T0, DST_T0, 5'd16);
			5'd16:   u = mk(UK_ALU, ALU_SUB, SRC_TAU, SRC_T0, DST_TAU, PC_RESID);
			5'd17:   u = mk(UK_ALU, ALU_DIV, SRC_REF, SRC_TAU, DST_T0, PC_LAST);
			default: u = mk(UK_CHECK, ALU_ADD, SRC_ZERO, SRC_ZERO, DST_T0, PC_LAST);
		endcase
		return u;
	endfunction

endpackage

FILE: hw/rtl/interface_temp_newton_solver_unit.sv
`timescale 1ns / 1ps
// Interface temperature solver: one void fraction word in, one temperature word out
// (Q23.40). All arithmetic runs on one shared multi-cycle unit (saturating add/sub,
// multiply from four registered 32x32 partial products, divide at one quotient bit a
// cycle, shift-add logarithm), stepped by a small microprogram, so one item is in flight
// at a time. An item runs the seed and first residual, then Newton steps (each one log,
// two divides, two multiplies), then a final divide; a cell with no vapor skips the
// microprogram. A finished word sits in the output register while the next item is
// taken. Configuration is accepted only while idle.
module interface_temp_newton_solver_unit #(
	parameter int FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [42:0] void_fraction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [62:0]        interface_temp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import itns_pkg::*;

	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	// configuration registers
	logic [62:0]        ref_temp_q, inv_ref_q, gas_lat_q, tol_q;
	logic signed [63:0] coef_const_q, coef_slope_q;
	logic [7:0]         max_iter_q;

	seq_state_t         state_q, state_d;
	logic [PC_W-1:0]    pc_q;
	logic [7:0]         iter_q;
	logic signed [63:0] alpha_q, lna_q, tau_q, err_q, t0_q, t1_q;
	logic               result_valid_q;
	logic [62:0]        temp_q;

	uop_t               uop;
	alu_req_t           alu_req;
	logic               alu_done;
	logic signed [63:0] alu_res, opa, opb;
	logic signed [63:0] eps, alpha_raw;
	logic               no_vapor, item_take, load_out, cfg_take, keep_going;
	logic [63:0]        err_mag;

	assign uop       = uop_at(pc_q);
	assign eps       = {{21{void_fraction[42]}}, void_fraction};
	assign alpha_raw = ONE - eps;
	assign no_vapor  = alpha_raw[63] || (alpha_raw == 64'sd0);
	assign err_mag   = err_q[63] ? (64'd0 - err_q) : err_q;
	assign keep_going = (err_mag > {1'b0, tol_q}) && (iter_q != max_iter_q);
	assign cfg_take  = cfg_valid && cfg_ready;

	function automatic logic signed [63:0] operand(input src_t s);
		unique case (s)
			SRC_ZERO:  return 64'sd0;
			SRC_ONE:   return ONE;
			SRC_ALPHA: return alpha_q;
			SRC_LNA:   return lna_q;
			SRC_TAU:   return tau_q;
			SRC_ERR:   return err_q;
			SRC_T0:    return t0_q;
			SRC_T1:    return t1_q;
			SRC_REF:   return {1'b0, ref_temp_q};
			SRC_INV:   return {1'b0, inv_ref_q};
			SRC_GOL:   return {1'b0, gas_lat_q};
			SRC_CC:    return coef_const_q;
			SRC_CS:    return coef_slope_q;
			default:   return 64'sd0;
		endcase
	endfunction

	assign opa = operand(uop.a);
	assign opb = operand(uop.b);

	itns_arith #(
		.FRAC_BITS(FRAC_BITS)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opa),
		.b      (opb),
		.done   (alu_done),
		.result (alu_res)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE:  if (item_valid) state_d = no_vapor ? SQ_FIN : SQ_ISSUE;
			SQ_ISSUE: if (uop.kind == UK_ALU) state_d = SQ_WAIT;
			SQ_WAIT:  if (alu_done) state_d = (pc_q == PC_LAST) ? SQ_FIN : SQ_ISSUE;
			SQ_FIN:   if (!result_valid_q || !result_stall) state_d = SQ_IDLE;
			default:  state_d = SQ_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall    = (state_q != SQ_IDLE);
		cfg_ready     = (state_q == SQ_IDLE);
		item_take     = (state_q == SQ_IDLE) && item_valid;
		load_out      = (state_q == SQ_FIN) && (!result_valid_q || !result_stall);
		alu_req.start = (state_q == SQ_ISSUE) && (uop.kind == UK_ALU);
		alu_req.op    = uop.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= SQ_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_temp_q   <= 63'd410117837160448;
			inv_ref_q    <= 63'd2947752353;
			gas_lat_q    <= '0;
			coef_const_q <= '0;
			coef_slope_q <= '0;
			tol_q        <= 63'd1024;
			max_iter_q   <= 8'd16;
		end else if (cfg_take) begin
			unique case (cfg_index)
				CFG_REF_TEMP:   ref_temp_q   <= cfg_data[62:0];
				CFG_INV_REF:    inv_ref_q    <= cfg_data[62:0];
				CFG_GAS_LAT:    gas_lat_q    <= cfg_data[62:0];
				CFG_COEF_CONST: coef_const_q <= cfg_data;
				CFG_COEF_SLOPE: coef_slope_q <= cfg_data;
				CFG_TOLERANCE:  tol_q        <= cfg_data[62:0];
				CFG_MAX_ITER:   max_iter_q   <= cfg_data[7:0];
				default:        max_iter_q   <= max_iter_q;
			endcase
		end
	end

	// program counter and iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_SEED;
			iter_q <= '0;
		end else if (item_take) begin
			pc_q   <= PC_SEED;
			iter_q <= '0;
		end else if (state_q == SQ_ISSUE && uop.kind == UK_CHECK) begin
			if (keep_going) begin
				pc_q   <= uop.nxt;
				iter_q <= iter_q + 8'd1;
			end else begin
				pc_q <= PC_LAST;
			end
		end else if (state_q == SQ_WAIT && alu_done) begin
			pc_q <= uop.nxt;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (item_take) begin
			alpha_q <= (alpha_raw > ONE) ? ONE : alpha_raw;
			t0_q    <= 64'sd0;
		end else if (state_q == SQ_WAIT && alu_done) begin
			unique case (uop.dst)
				DST_LNA: lna_q <= alu_res;
				DST_TAU: tau_q <= alu_res;
				DST_ERR: err_q <= alu_res;
				DST_T0:  t0_q  <= alu_res;
				DST_T1:  t1_q  <= alu_res;
				default: t1_q  <= t1_q;
			endcase
		end
		if (load_out)
			temp_q <= t0_q[63] ? 63'd0 : t0_q[62:0];
	end

	assign result_valid   = result_valid_q;
	assign interface_temp = temp_q;

	// the shared unit only reports while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n) alu_done |-> state_q == SQ_WAIT)
		else $error("arith done outside wait");

	// newton steps never run past the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != SQ_IDLE |-> iter_q <= max_iter_q)
		else $error("iteration count over limit");

	// microprogram stays inside its program
	assert property (@(posedge clk) disable iff (!arst_n) pc_q <= PC_LAST)
		else $error("program counter out of range");

	// a final word is only loaded once the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(interface_temp) || !result_valid)
		else $error("output word overwritten while stalled");

endmodule

FILE: hw/rtl/itns_arith.sv
`timescale 1ns / 1ps
module itns_arith #(
	parameter int FRAC_BITS = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  itns_pkg::alu_req_t       req,
	input  logic signed [63:0]       a,
	input  logic signed [63:0]       b,
	output logic                     done,
	output logic signed [63:0]       result
);
	import itns_pkg::*;

	localparam logic [63:0] MAXV = {1'b0, {63{1'b1}}};
	localparam logic [63:0] MINV = {1'b1, {63{1'b0}}};
	localparam logic [63:0] ONES = {64{1'b1}};
	localparam logic [63:0] LN2R =
		(LN_TAB[1] + (64'd1 << (LOG_BITS - 1 - FRAC_BITS))) >> (LOG_BITS - FRAC_BITS);
	localparam logic [63:0] RND = 64'd1 << (LOG_BITS - 1 - FRAC_BITS);
	localparam logic [63:0] LOG_ONE = 64'd1 << LOG_BITS;
	localparam logic [7:0] EXP_BASE = 8'(62 - FRAC_BITS);

	ar_state_t   st_q, st_d;
	logic [63:0] x_q, y_q;
	logic        neg_q, aneg_q;
	logic [6:0]  cnt_q;
	logic [63:0] pp_q;
	logic [1:0]  pp_sh_q;
	logic [127:0] prod_q;
	logic [63:0] rem_q, lo_q, quo_q;
	logic [63:0] m_q, acc_q;
	logic [5:0]  sh_q, k_q;
	logic signed [63:0] res_q;

	// saturate a magnitude with a sign
	function automatic logic [63:0] sat_sign(input logic [63:0] m, input logic neg);
		if (neg)
			return m[63] ? MINV : (64'd0 - m);
		return m[63] ? MAXV : m;
	endfunction

	function automatic logic [63:0] mag(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	logic        a_nonpos;
	logic [64:0] sum;
	logic [64:0] rem0;
	logic [64:0] r2;
	logic        ge;
	logic [63:0] lt;
	logic        norm_top;
	logic signed [7:0]  ln_exp;
	logic signed [71:0] ln_prod;

	assign a_nonpos = a[63] || (a == 64'sd0);
	assign rem0     = {1'b0, x_q >> (64 - FRAC_BITS)};
	assign r2       = {rem_q, lo_q[63]};
	assign ge       = r2 >= {1'b0, y_q};
	assign lt       = m_q - (m_q >> k_q);
	assign norm_top = m_q[62];
	assign ln_exp   = $signed(EXP_BASE - {2'b00, sh_q});
	assign ln_prod  = ln_exp * $signed({8'd0, LN2R});

	// saturating add or subtract
	always_comb begin
		if (req.op == ALU_SUB)
			sum = {a[63], a} - {b[63], b};
		else
			sum = {a[63], a} + {b[63], b};
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			AR_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						ALU_ADD, ALU_SUB: st_d = AR_DONE;
						ALU_MUL:          st_d = AR_MUL;
						ALU_DIV:          st_d = AR_DSET;
						ALU_LN:           st_d = a_nonpos ? AR_DONE : AR_NORM;
						default:          st_d = AR_DONE;
					endcase
				end
			end
			AR_MUL:  if (cnt_q == 7'd4) st_d = AR_MULF;
			AR_MULF: st_d = AR_DONE;
			AR_DSET: begin
				if (y_q == 64'd0 || rem0 >= {1'b0, y_q})
					st_d = AR_DONE;
				else
					st_d = AR_DIV;
			end
			AR_DIV:  if (cnt_q == 7'd63) st_d = AR_DIVF;
			AR_DIVF: st_d = AR_DONE;
			AR_NORM: if (norm_top) st_d = AR_LOG;
			AR_LOG:  if (k_q == 6'(LOG_BITS)) st_d = AR_LNF;
			AR_LNF:  st_d = AR_DONE;
			AR_DONE: st_d = AR_IDLE;
			default: st_d = AR_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done   = (st_q == AR_DONE);
		result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= AR_IDLE;
		else
			st_q <= st_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			AR_IDLE: begin
				if (req.start) begin
					x_q    <= mag(a);
					y_q    <= mag(b);
					neg_q  <= a[63] ^ b[63];
					aneg_q <= a[63];
					cnt_q  <= '0;
					prod_q <= '0;
					m_q    <= a;
					sh_q   <= '0;
					unique case (req.op)
						ALU_ADD, ALU_SUB:
							res_q <= (sum[64] != sum[63]) ? (sum[64] ? MINV : MAXV) : sum[63:0];
						ALU_LN:  res_q <= MINV;
						default: res_q <= res_q;
					endcase
				end
			end
			// four 32x32 partial products, each registered before accumulation
			AR_MUL: begin
				if (cnt_q < 7'd4) begin
					pp_q    <= x_q[32*cnt_q[1] +: 32] * y_q[32*cnt_q[0] +: 32];
					pp_sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
				end
				if (cnt_q != 7'd0)
					prod_q <= prod_q + ({64'd0, pp_q} << (32 * pp_sh_q));
				cnt_q <= cnt_q + 7'd1;
			end
			AR_MULF: begin
				if (|prod_q[127:64+FRAC_BITS])
					res_q <= sat_sign(ONES, neg_q);
				else
					res_q <= sat_sign(prod_q[FRAC_BITS+63:FRAC_BITS], neg_q);
			end
			AR_DSET: begin
				if (y_q == 64'd0)
					res_q <= sat_sign(ONES, aneg_q);
				else if (rem0 >= {1'b0, y_q})
					res_q <= sat_sign(ONES, neg_q);
				rem_q <= rem0[63:0];
				lo_q  <= x_q << FRAC_BITS;
				quo_q <= '0;
				cnt_q <= '0;
			end
			// one quotient bit a cycle
			AR_DIV: begin
				rem_q <= ge ? 64'(r2 - {1'b0, y_q}) : r2[63:0];
				lo_q  <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], ge};
				cnt_q <= cnt_q + 7'd1;
			end
			AR_DIVF: res_q <= sat_sign(quo_q, neg_q);
			// leading one to bit 62, then down to the log format
			AR_NORM: begin
				if (norm_top) begin
					m_q   <= m_q >> 2;
					k_q   <= 6'd1;
					acc_q <= '0;
				end else if (m_q[62:55] == 8'd0) begin
					m_q  <= m_q << 8;
					sh_q <= sh_q + 6'd8;
				end else begin
					m_q  <= m_q << 1;
					sh_q <= sh_q + 6'd1;
				end
			end
			// shift-add logarithm, one factor a cycle
			AR_LOG: begin
				if (lt >= LOG_ONE) begin
					m_q   <= lt;
					acc_q <= acc_q + LN_TAB[k_q];
				end
				k_q <= k_q + 6'd1;
			end
			AR_LNF: res_q <= ln_prod[63:0] + ((acc_q + RND) >> (LOG_BITS - FRAC_BITS));
			AR_DONE: res_q <= res_q;
			default: res_q <= res_q;
		endcase
	end

endmodule
